// ===== sv/tcdr_pkg.sv =====
// Package for the two-bank character-cell display store.
// Holds field widths, default sizes, action and register codes.
// No dependencies.
package tcdr_pkg;

    localparam int MAX_COLUMNS_DEF = 16;
    localparam int MAX_ROWS_DEF    = 4;

    localparam int CELL_W   = 16;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;

    localparam logic [4:0] COLS_RESET = 5'd16;
    localparam logic [2:0] ROWS_RESET = 3'd4;

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_FILL    = 2'd1,
        ACT_REFRESH = 2'd2,
        ACT_SWAP    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_COLS_IN_USE = 2'd0,
        REG_ROWS_IN_USE = 2'd1,
        REG_COL_OFFSET  = 2'd2,
        REG_ROW_OFFSET  = 2'd3
    } cfg_reg_t;

endpackage

// ===== sv/text_cell_diff_refresh.sv =====
// Top level of the two-bank character-cell display store.
// Depends on tcdr_pkg and tcdr_ram.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready with the action in s_tuser and
//   row, column, char_code and style in s_tdata. Result words leave on
//   m_tvalid/m_tready: page, column_address, cell_char, cell_style in
//   m_tdata, changed in m_tuser, last in m_tlast. Size and offset
//   registers are written through cfg_we/cfg_addr/cfg_wdata, by the user
//   only while idle; the block does not enforce it. Fill holds s_tready
//   low while it writes each in-use cell of the current bank, one write
//   per cycle. Refresh reads both banks at one cell per cycle unless the
//   scan halts, and holds s_tready low until it loads the final word. One
//   difference is held back so the final one can carry last; the scan
//   halts on a further difference while that word and the output register
//   are both full. A held word reaches m_tvalid in the cycle after the next
//   differing cell is compared, the final word in the cycle after the
//   flush. A stalled receiver holds the output register; inputs are taken
//   while idle. After reset s_tready stays low while both banks are cleared
//   over all 2**(row bits + column bits) addresses (64 at default size).
module text_cell_diff_refresh #(
    parameter int MAX_COLUMNS = tcdr_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tcdr_pkg::MAX_ROWS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // row[1:0], column[5:2], char_code[13:6], style[21:14], zero[23:22]
    input  logic [tcdr_pkg::IN_DATA_W-1:0]    s_tdata,
    // action[1:0]
    input  logic [tcdr_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // page[2:0], column_address[9:3], cell_char[17:10], cell_style[25:18],
    // zero[31:26]
    output logic [tcdr_pkg::OUT_DATA_W-1:0]   m_tdata,
    // changed[0]
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [tcdr_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [tcdr_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int CEL_W = tcdr_pkg::CELL_W;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_FILL  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic             bank_reg, bank_next;
    logic [4:0]       cols_reg;
    logic [2:0]       rows_reg;
    logic [3:0]       coff_reg;
    logic [1:0]       roff_reg;
    logic [RW-1:0]    r_reg, r_next;
    logic [CW-1:0]    c_reg, c_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [CEL_W-1:0] fill_data_reg, fill_data_next;

    logic             hold_valid_reg, hold_valid_next;
    logic [2:0]       hold_page_reg, hold_page_next;
    logic [6:0]       hold_col_reg, hold_col_next;
    logic [CEL_W-1:0] hold_cell_reg, hold_cell_next;

    logic             out_valid_reg, out_valid_next;
    logic [2:0]       out_page_reg, out_page_next;
    logic [6:0]       out_col_reg, out_col_next;
    logic [CEL_W-1:0] out_cell_reg, out_cell_next;
    logic             out_changed_reg, out_changed_next;
    logic             out_last_reg, out_last_next;

    tcdr_pkg::action_t in_action;
    logic [1:0]       in_row;
    logic [3:0]       in_col;
    logic [CEL_W-1:0] in_cell;
    logic             in_accept;

    logic [6:0]       nc;
    logic [4:0]       nr;
    logic             area_empty;
    logic             wr_ok;
    logic             row_end;
    logic             all_end;
    logic [AW-1:0]    cur_addr;
    logic [AW-1:0]    next_addr;
    logic [AW-1:0]    in_addr;
    logic [7:0]       in_row8;
    logic [7:0]       in_col8;
    logic [7:0]       r8;
    logic [7:0]       c8;
    logic [1:0]       page_sum;
    logic [3:0]       col_sum;
    logic [2:0]       pos_page;
    logic [6:0]       pos_col;

    logic             we_cur;
    logic             we0, we1;
    logic [AW-1:0]    waddr, raddr;
    logic [CEL_W-1:0] wdata;
    logic [CEL_W-1:0] rd0, rd1;
    logic [CEL_W-1:0] cur_data, old_data;
    logic             differ;
    logic             out_free;
    logic             advance;

    tcdr_ram #(
        .WIDTH (CEL_W),
        .DEPTH (DEPTH)
    ) u_bank_zero (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd0)
    );

    tcdr_ram #(
        .WIDTH (CEL_W),
        .DEPTH (DEPTH)
    ) u_bank_one (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd1)
    );

    // unpack and decode
    always_comb
    begin
        in_action = tcdr_pkg::action_t'(s_tuser);
        in_row    = s_tdata[1:0];
        in_col    = s_tdata[5:2];
        in_cell   = {s_tdata[21:14], s_tdata[13:6]};
        s_tready  = (state_reg == ST_IDLE);
        in_accept = s_tvalid && s_tready;

        nc = (7'(cols_reg) > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : 7'(cols_reg);
        nr = (5'(rows_reg) > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : 5'(rows_reg);
        area_empty = (nc == 7'd0) || (nr == 5'd0);
        wr_ok = (5'(in_row) < nr) && (7'(in_col) < nc);

        in_row8 = 8'(in_row);
        in_col8 = 8'(in_col);
        in_addr = {in_row8[RW-1:0], in_col8[CW-1:0]};

        row_end  = (7'(c_reg) + 7'd1 == nc);
        all_end  = row_end && (5'(r_reg) + 5'd1 == nr);
        cur_addr = {r_reg, c_reg};
        next_addr = row_end ? {r_reg + RW'(1), CW'(0)} : {r_reg, c_reg + CW'(1)};

        r8 = 8'(r_reg);
        c8 = 8'(c_reg);
        page_sum = roff_reg + r8[1:0];
        col_sum  = coff_reg + c8[3:0];
        pos_page = {page_sum, 1'b0};
        pos_col  = {col_sum, 3'b000};

        cur_data = bank_reg ? rd1 : rd0;
        old_data = bank_reg ? rd0 : rd1;
        differ   = (cur_data != old_data);
        out_free = !out_valid_reg || m_tready;
        advance  = !differ || !hold_valid_reg || out_free;
    end

    // RAM ports
    always_comb
    begin
        we_cur = 1'b0;
        waddr  = cur_addr;
        wdata  = fill_data_reg;
        raddr  = cur_addr;
        we0    = 1'b0;
        we1    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                waddr = clr_reg;
                wdata = '0;
                we0   = 1'b1;
                we1   = 1'b1;
            end
            ST_IDLE:
            begin
                waddr  = in_addr;
                wdata  = in_cell;
                raddr  = '0;
                we_cur = in_accept && (in_action == tcdr_pkg::ACT_WRITE) && wr_ok;
            end
            ST_FILL:
            begin
                we_cur = 1'b1;
            end
            ST_SCAN:
            begin
                raddr = advance ? next_addr : cur_addr;
            end
            default:
            begin
                we_cur = 1'b0;
            end
        endcase
        if (we_cur)
        begin
            we0 = !bank_reg;
            we1 = bank_reg;
        end
    end

    // control and data path next values
    always_comb
    begin
        state_next       = state_reg;
        bank_next        = bank_reg;
        r_next           = r_reg;
        c_next           = c_reg;
        clr_next         = clr_reg;
        fill_data_next   = fill_data_reg;
        hold_valid_next  = hold_valid_reg;
        hold_page_next   = hold_page_reg;
        hold_col_next    = hold_col_reg;
        hold_cell_next   = hold_cell_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_page_next    = out_page_reg;
        out_col_next     = out_col_reg;
        out_cell_next    = out_cell_reg;
        out_changed_next = out_changed_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    r_next = '0;
                    c_next = '0;
                    case (in_action)
                        tcdr_pkg::ACT_FILL:
                        begin
                            fill_data_next = in_cell;
                            if (!area_empty)
                            begin
                                state_next = ST_FILL;
                            end
                        end
                        tcdr_pkg::ACT_REFRESH:
                        begin
                            state_next = area_empty ? ST_FLUSH : ST_SCAN;
                        end
                        tcdr_pkg::ACT_SWAP:
                        begin
                            bank_next = !bank_reg;
                        end
                        default:
                        begin
                            bank_next = bank_reg;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                if (all_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    {r_next, c_next} = next_addr;
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    if (differ)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next   = 1'b1;
                            out_page_next    = hold_page_reg;
                            out_col_next     = hold_col_reg;
                            out_cell_next    = hold_cell_reg;
                            out_changed_next = 1'b1;
                            out_last_next    = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_page_next  = pos_page;
                        hold_col_next   = pos_col;
                        hold_cell_next  = cur_data;
                    end
                    if (all_end)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        {r_next, c_next} = next_addr;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_last_next    = 1'b1;
                    out_changed_next = hold_valid_reg;
                    out_page_next    = hold_valid_reg ? hold_page_reg : 3'd0;
                    out_col_next     = hold_valid_reg ? hold_col_reg : 7'd0;
                    out_cell_next    = hold_valid_reg ? hold_cell_reg : '0;
                    hold_valid_next  = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            bank_reg       <= 1'b0;
            clr_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cols_reg       <= tcdr_pkg::COLS_RESET;
            rows_reg       <= tcdr_pkg::ROWS_RESET;
            coff_reg       <= 4'd0;
            roff_reg       <= 2'd0;
        end
        else
        begin
            state_reg      <= state_next;
            bank_reg       <= bank_next;
            clr_reg        <= clr_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (tcdr_pkg::cfg_reg_t'(cfg_addr))
                    tcdr_pkg::REG_COLS_IN_USE: cols_reg <= cfg_wdata;
                    tcdr_pkg::REG_ROWS_IN_USE: rows_reg <= cfg_wdata[2:0];
                    tcdr_pkg::REG_COL_OFFSET:  coff_reg <= cfg_wdata[3:0];
                    tcdr_pkg::REG_ROW_OFFSET:  roff_reg <= cfg_wdata[1:0];
                    default:                   roff_reg <= roff_reg;
                endcase
            end
        end
    end

    // payload and position registers
    always_ff @(posedge clk)
    begin
        r_reg           <= r_next;
        c_reg           <= c_next;
        fill_data_reg   <= fill_data_next;
        hold_page_reg   <= hold_page_next;
        hold_col_reg    <= hold_col_next;
        hold_cell_reg   <= hold_cell_next;
        out_page_reg    <= out_page_next;
        out_col_reg     <= out_col_next;
        out_cell_reg    <= out_cell_next;
        out_changed_reg <= out_changed_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_cell_reg[15:8], out_cell_reg[7:0], out_col_reg, out_page_reg};
    assign m_tuser  = out_changed_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== sv/tcdr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module tcdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/sv/tcdr_board_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the two-bank character-cell display store: a predictor of
// both banks and the size registers, and the queue of result words due.
// Depends on tcdr_pkg for sizes, reset values, action and register codes.
package tcdr_board_pkg;
    import tcdr_pkg::*;

    localparam int ROW_STRIDE = MAX_COLUMNS_DEF;
    localparam int BANK_CELLS = MAX_COLUMNS_DEF * MAX_ROWS_DEF;

    typedef struct packed {
        logic [2:0] page;
        logic [6:0] column_address;
        logic [7:0] cell_char;
        logic [7:0] cell_style;
        logic       changed;
        logic       last;
    } cell_report_t;

    class cell_diff_board;
        logic [15:0]  cells [2 * BANK_CELLS];
        logic         cur_bank;
        logic [4:0]   cols_in_use;
        logic [2:0]   rows_in_use;
        logic [3:0]   column_offset;
        logic [1:0]   row_offset;
        cell_report_t due_reports [$];
        int           fails;
        int           checked;

        function new();
            foreach (cells[i])
            begin
                cells[i] = '0;
            end
            cur_bank      = 1'b0;
            cols_in_use   = COLS_RESET;
            rows_in_use   = ROWS_RESET;
            column_offset = '0;
            row_offset    = '0;
            fails         = 0;
            checked       = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [4:0] value);
            case (idx)
                REG_COLS_IN_USE: cols_in_use   = value;
                REG_ROWS_IN_USE: rows_in_use   = value[2:0];
                REG_COL_OFFSET:  column_offset = value[3:0];
                REG_ROW_OFFSET:  row_offset    = value[1:0];
                default: ;
            endcase
        endfunction

        function int waiting();
            return due_reports.size();
        endfunction

        function void note_word(action_t act, logic [1:0] row, logic [3:0] column,
                                logic [7:0] ch, logic [7:0] st);
            int           nc;
            int           nr;
            int           cur_base;
            int           old_base;
            int           idx;
            cell_report_t rep;
            cell_report_t held;
            bit           have_held;
            nc = (cols_in_use > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(cols_in_use);
            nr = (rows_in_use > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_in_use);
            cur_base  = cur_bank ? BANK_CELLS : 0;
            old_base  = cur_bank ? 0 : BANK_CELLS;
            have_held = 1'b0;
            held      = '0;
            case (act)
                ACT_WRITE:
                begin
                    if (int'(row) < nr && int'(column) < nc)
                    begin
                        cells[cur_base + int'(row) * ROW_STRIDE + int'(column)] = {st, ch};
                    end
                end
                ACT_FILL:
                begin
                    for (int r = 0; r < nr; r++)
                    begin
                        for (int c = 0; c < nc; c++)
                        begin
                            cells[cur_base + r * ROW_STRIDE + c] = {st, ch};
                        end
                    end
                end
                ACT_SWAP:
                begin
                    cur_bank = ~cur_bank;
                end
                default:
                begin
                    // hold one difference back so the final one can carry last
                    for (int r = 0; r < nr; r++)
                    begin
                        for (int c = 0; c < nc; c++)
                        begin
                            idx = r * ROW_STRIDE + c;
                            if (cells[cur_base + idx] != cells[old_base + idx])
                            begin
                                rep.page           = 3'((int'(row_offset) + r) * 2);
                                rep.column_address = 7'((int'(column_offset) + c) * 8);
                                rep.cell_char      = cells[cur_base + idx][7:0];
                                rep.cell_style     = cells[cur_base + idx][15:8];
                                rep.changed        = 1'b1;
                                rep.last           = 1'b0;
                                if (have_held)
                                begin
                                    due_reports.push_back(held);
                                end
                                held      = rep;
                                have_held = 1'b1;
                            end
                        end
                    end
                    if (!have_held)
                    begin
                        held = '0;
                    end
                    held.last = 1'b1;
                    due_reports.push_back(held);
                end
            endcase
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_word(logic [31:0] data, logic chg, logic lst);
            cell_report_t want;
            if (due_reports.size() == 0)
            begin
                $error("result word with nothing due: data %h changed %b last %b",
                       data, chg, lst);
                fails++;
                return;
            end
            want = due_reports.pop_front();
            checked++;
            compare("page", 8'(want.page), 8'(data[2:0]));
            compare("column_address", 8'(want.column_address), 8'(data[9:3]));
            compare("cell_char", want.cell_char, data[17:10]);
            compare("cell_style", want.cell_style, data[25:18]);
            compare("changed", 8'(want.changed), 8'(chg));
            compare("last", 8'(want.last), 8'(lst));
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_text_cell_diff_refresh.sv =====
`timescale 1ns / 1ps
// Top-level testbench for text_cell_diff_refresh: drives write, fill, refresh
// and swap words under bursty input and a stalling receiver, over many sizes.
// Depends on tcdr_pkg, tcdr_board_pkg and the block's RTL.
module tb_text_cell_diff_refresh;
    import tcdr_pkg::*;
    import tcdr_board_pkg::*;

    localparam int SETTLE_CYCLES = 100;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_ITEMS  = 150;

    typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_SELDOM, READY_PULSED} ready_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    cell_diff_board board = new();

    int          burst_left     = 0;
    int          items_sent     = 0;
    int          settings_used  = 0;
    int          area_cols      = 16;
    int          area_rows      = 4;
    ready_mode_t ready_mode     = READY_ALWAYS;
    int          ready_left     = 0;
    int          idle_cycles    = 0;

    text_cell_diff_refresh i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic send_word(input action_t act, input logic [1:0] row,
                             input logic [3:0] column, input logic [7:0] ch,
                             input logic [7:0] st);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tdata  <= {2'b00, st, ch, column, row};
        s_tuser  <= act;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        board.note_word(act, row, column, ch, st);
        items_sent++;
    endtask

    task automatic send_random_word(input action_t act);
        logic [1:0] row;
        logic [3:0] column;
        row    = 2'($urandom_range(0, 3));
        column = 4'($urandom_range(0, 15));
        // aim most writes inside the area in use
        if (act == ACT_WRITE && area_cols > 0 && area_rows > 0 && $urandom_range(0, 4) != 0)
        begin
            row    = 2'($urandom_range(0, area_rows - 1));
            column = 4'($urandom_range(0, area_cols - 1));
        end
        send_word(act, row, column, 8'($urandom), 8'($urandom));
    endtask

    task automatic drain_results(input int extra);
        s_tvalid <= 1'b0;
        while (board.waiting() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_reg_t idx, input logic [4:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        board.write_reg(idx, value);
    endtask

    task automatic apply_setting(input logic [4:0] cols, input logic [2:0] rows,
                                 input logic [3:0] coff, input logic [1:0] roff);
        write_cfg(REG_COLS_IN_USE, cols);
        write_cfg(REG_ROWS_IN_USE, {2'b00, rows});
        write_cfg(REG_COL_OFFSET, {1'b0, coff});
        write_cfg(REG_ROW_OFFSET, {3'b000, roff});
        cfg_we <= 1'b0;
        area_cols = (cols > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(cols);
        area_rows = (rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows);
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.check_word(m_tdata, m_tuser, m_tlast);
        end
        if (ready_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(8, 60);
        end
        else
        begin
            ready_left--;
        end
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            READY_SELDOM: m_tready <= ($urandom_range(0, 3) == 0);
            default:      m_tready <= ready_left[2];
        endcase
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $error("no word moved for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int random_goal;
        int phase_end;
        int frame_writes;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // hold off until the clearing pass is over
        while (!s_tready) @(posedge clk);
        apply_setting(5'd16, 3'd4, 4'd0, 2'd0);

        send_word(ACT_REFRESH, 2'd0, 4'd0, 8'h00, 8'h00);
        send_word(ACT_WRITE, 2'd0, 4'd0, 8'hFF, 8'hFF);
        send_word(ACT_WRITE, 2'd3, 4'd15, 8'h01, 8'h80);
        send_word(ACT_WRITE, 2'd2, 4'd9, 8'h5A, 8'hA5);
        send_word(ACT_WRITE, 2'd1, 4'd4, 8'h00, 8'h00);
        send_word(ACT_REFRESH, 2'd3, 4'd15, 8'hFF, 8'hFF);
        send_word(ACT_SWAP, 2'd0, 4'd0, 8'h00, 8'h00);
        send_word(ACT_REFRESH, 2'd0, 4'd0, 8'h00, 8'h00);
        send_word(ACT_FILL, 2'd0, 4'd0, 8'hAA, 8'h55);
        send_word(ACT_REFRESH, 2'd0, 4'd0, 8'h00, 8'h00);
        send_word(ACT_SWAP, 2'd3, 4'd15, 8'hFF, 8'hFF);
        send_word(ACT_REFRESH, 2'd0, 4'd0, 8'h00, 8'h00);
        send_word(ACT_FILL, 2'd0, 4'd0, 8'hAA, 8'h55);
        send_word(ACT_REFRESH, 2'd0, 4'd0, 8'h00, 8'h00);
        drain_results(SETTLE_CYCLES);

        apply_setting(5'd1, 3'd1, 4'd15, 2'd3);
        send_word(ACT_WRITE, 2'd0, 4'd0, 8'hC3, 8'h3C);
        send_word(ACT_WRITE, 2'd0, 4'd1, 8'h77, 8'h77);
        send_word(ACT_WRITE, 2'd1, 4'd0, 8'h77, 8'h77);
        send_word(ACT_REFRESH, 2'd0, 4'd0, 8'h00, 8'h00);
        send_word(ACT_FILL, 2'd0, 4'd0, 8'h00, 8'h00);
        send_word(ACT_REFRESH, 2'd0, 4'd0, 8'h00, 8'h00);
        drain_results(SETTLE_CYCLES);

        apply_setting(5'd0, 3'd4, 4'd7, 2'd1);
        send_word(ACT_WRITE, 2'd0, 4'd0, 8'h11, 8'h22);
        send_word(ACT_FILL, 2'd0, 4'd0, 8'h33, 8'h44);
        send_word(ACT_REFRESH, 2'd0, 4'd0, 8'h00, 8'h00);
        drain_results(SETTLE_CYCLES);

        apply_setting(5'd31, 3'd7, 4'd15, 2'd3);
        send_word(ACT_REFRESH, 2'd0, 4'd0, 8'h00, 8'h00);
        send_word(ACT_SWAP, 2'd0, 4'd0, 8'h00, 8'h00);

        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal)
        begin
            drain_results(SETTLE_CYCLES);
            case ($urandom_range(0, 6))
                0: apply_setting(5'd1, 3'd1, 4'd0, 2'd0);
                1: apply_setting(5'd31, 3'd7, 4'd15, 2'd3);
                2: apply_setting(5'($urandom_range(0, 1) * $urandom_range(1, 31)),
                                 3'($urandom_range(0, 7)), 4'($urandom), 2'($urandom));
                3: apply_setting(5'd16, 3'd4, 4'($urandom), 2'($urandom));
                default: apply_setting(5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                                       4'($urandom), 2'($urandom));
            endcase
            phase_end = items_sent + $urandom_range(20, 40);
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    drain_results(1);
                end
                if ($urandom_range(0, 6) == 0)
                begin
                    send_random_word(action_t'($urandom_range(0, 3)));
                end
                else
                begin
                    // one frame: optional fill, a few cell writes, refresh, usually swap
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_random_word(ACT_FILL);
                    end
                    frame_writes = $urandom_range(1, 8);
                    repeat (frame_writes) send_random_word(ACT_WRITE);
                    send_random_word(ACT_REFRESH);
                    if ($urandom_range(0, 9) < 7)
                    begin
                        send_random_word(ACT_SWAP);
                    end
                end
            end
        end
        drain_results(SETTLE_CYCLES);

        $display("Covered %0d input words over %0d size and offset settings,",
                 items_sent, settings_used);
        $display("with %0d result words compared and %0d mismatches.",
                 board.checked, board.fails);
        if (board.fails == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/tcdr_pkg.sv
sv/tcdr_ram.sv
sv/text_cell_diff_refresh.sv
tb/sv/tcdr_board_pkg.sv
tb/sv/tb_text_cell_diff_refresh.sv
